// ===== rtl/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame deframer package
// Shared constants, codes and types of the CRC-checked frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam logic [7:0]  START_BYTE = 8'h07;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] POLY_RESET = 16'h1021;

  // Receive phases, one-hot.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_CHECK   = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DISCARD = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_CRC_ERR = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  vpid;
    logic [7:0]  stream;
    logic [15:0] payload_len;
    logic        last;
  } res_t;

  // One processing step's outcome, handed from the frame control to the top.
  typedef struct packed {
    logic valid;
    res_t res;
  } res_beat_t;

endpackage

// ===== rtl/cfd_if.sv =====
// ----------------------------------------------------------------------------
// Frame deframer channels
// Valid/ready channels for received bytes, results and the polynomial write.
// ----------------------------------------------------------------------------
interface cfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic [7:0]  vpid;
  logic [7:0]  stream;
  logic [15:0] payload_len;
  logic        last;

  modport source (output valid, output kind, output data, output vpid, output stream,
                  output payload_len, output last, input ready);
  modport sink   (input valid, input kind, input data, input vpid, input stream,
                  input payload_len, input last, output ready);
endinterface

interface cfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_poly;

  modport source (output valid, output crc_poly, input ready);
  modport sink   (input valid, input crc_poly, output ready);
endinterface

// ===== rtl/cfd_crc_fold.sv =====
// ----------------------------------------------------------------------------
// CRC-16 byte fold
// Folds one byte into a CRC-16 accumulator, MSB first, unrolled over 8 bits.
// ----------------------------------------------------------------------------
module cfd_crc_fold (
  input  logic [15:0] acc_i,
  input  logic [7:0]  data_i,
  input  logic [15:0] poly_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] r;
    r = acc_i ^ {data_i, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ poly_i;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    crc_o = r;
  end

endmodule

// ===== rtl/cfd_frame_ctl.sv =====
// ----------------------------------------------------------------------------
// Frame control
// Phase machine that hunts for the start byte, collects and checks the header
// and passes the payload through, producing at most one result per word.
// ----------------------------------------------------------------------------
module cfd_frame_ctl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [15:0]        poly_i,
  output cfd_pkg::res_beat_t beat_o
);
  import cfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  count_q, count_d;
  logic [7:0]  chan_q, chan_d;
  logic [7:0]  stream_q, stream_d;
  logic [15:0] len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  chk_lo_q, chk_lo_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] crc_next;
  logic        fin;

  cfd_crc_fold u_crc_fold (
    .acc_i  (crc_q),
    .data_i (rx_byte_i),
    .poly_i (poly_i),
    .crc_o  (crc_next)
  );

  assign fin = (remain_q <= 16'd1);

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    chan_d   = chan_q;
    stream_d = stream_q;
    len_d    = len_q;
    crc_d    = crc_q;
    chk_lo_d = chk_lo_q;
    remain_d = remain_q;
    beat_o   = '0;

    case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == START_BYTE) begin
          phase_d = PH_HEADER;
          count_d = 2'd0;
          crc_d   = CRC_INIT;
        end else begin
          beat_o.valid    = 1'b1;
          beat_o.res.kind = KIND_DISCARD;
          beat_o.res.data = rx_byte_i;
        end
      end
      PH_HEADER: begin
        crc_d = crc_next;
        case (count_q)
          2'd0:    chan_d   = rx_byte_i;
          2'd1:    stream_d = rx_byte_i;
          2'd2:    len_d    = {len_q[15:8], rx_byte_i};
          default: len_d    = {rx_byte_i, len_q[7:0]};
        endcase
        if (count_q == 2'd3) begin
          phase_d = PH_CHECK;
          count_d = 2'd0;
        end else begin
          count_d = count_q + 2'd1;
        end
      end
      PH_CHECK: begin
        if (count_q == 2'd0) begin
          chk_lo_d = rx_byte_i;
          count_d  = 2'd1;
        end else begin
          count_d      = 2'd0;
          beat_o.valid = 1'b1;
          if ({rx_byte_i, chk_lo_q} == crc_q) begin
            beat_o.res.kind        = KIND_HEADER;
            beat_o.res.vpid        = chan_q;
            beat_o.res.stream      = stream_q;
            beat_o.res.payload_len = len_q;
            beat_o.res.last        = (len_q == 16'd0);
            remain_d               = len_q;
            phase_d                = (len_q == 16'd0) ? PH_HUNT : PH_PAYLOAD;
          end else begin
            beat_o.res.kind = KIND_CRC_ERR;
            phase_d         = PH_HUNT;
          end
        end
      end
      PH_PAYLOAD: begin
        beat_o.valid    = 1'b1;
        beat_o.res.kind = KIND_PAYLOAD;
        beat_o.res.data = rx_byte_i;
        beat_o.res.last = fin;
        remain_d        = fin ? 16'd0 : remain_q - 16'd1;
        if (fin) begin
          phase_d = PH_HUNT;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      count_q  <= 2'd0;
      chan_q   <= 8'd0;
      stream_q <= 8'd0;
      len_q    <= 16'd0;
      crc_q    <= CRC_INIT;
      chk_lo_q <= 8'd0;
      remain_q <= 16'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      chan_q   <= chan_d;
      stream_q <= stream_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      chk_lo_q <= chk_lo_d;
      remain_q <= remain_d;
    end
  end

  // A start byte seen while hunting opens a header with a fresh CRC.
  a_start_opens_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_HUNT && rx_byte_i == START_BYTE
    |=> phase_q == PH_HEADER && crc_q == CRC_INIT && count_q == 2'd0)
    else $error("start byte did not open a header");

  // The payload phase holds until the final counted byte.
  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_PAYLOAD && remain_q > 16'd1
    |=> phase_q == PH_PAYLOAD && remain_q == $past(remain_q) - 16'd1)
    else $error("payload phase left early");

  // An accepted header is marked last exactly when its payload is empty.
  a_header_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && beat_o.valid && beat_o.res.kind == KIND_HEADER
    |-> beat_o.res.last == (beat_o.res.payload_len == 16'd0))
    else $error("header last flag disagrees with length");

  // Header fields are carried only on an accepted header.
  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_o.valid && beat_o.res.kind != KIND_HEADER
    |-> beat_o.res.vpid == 8'd0 && beat_o.res.stream == 8'd0
        && beat_o.res.payload_len == 16'd0)
    else $error("header fields set on a non-header result");

endmodule

// ===== rtl/crc_checked_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// CRC-checked frame deframer
// Hunts for start byte 7, checks a four-byte header against a CRC-16 and
// passes the payload through.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one received byte per word. res_o carries one result word
//   (kind, data, vpid, stream, payload_len, last) for each byte that causes
//   one; the start byte, header bytes and first check byte cause none.
//   cfg_i writes the CRC polynomial (without the x^16 term); it is always
//   ready and should be written only while the block is idle.
//   A byte is registered on acceptance and processed once the output register
//   can take a result; processing writes its result into the output register.
//   One byte per cycle is sustained while res_o does not stall; the
//   byte-wide CRC fold and phase update sit in combinational logic between the
//   input and output registers.
//   When res_o stalls, the held byte waits in the input register and rx_i
//   drops ready until the output register drains.
//   Reset empties both registers, returns to hunting with a CRC of 0xFFFF
//   and sets the polynomial to 0x1021.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfd_cfg_if.sink   cfg_i,
  cfd_rx_if.sink    rx_i,
  cfd_res_if.source res_o
);
  import cfd_pkg::*;

  logic        rx_valid_q, rx_valid_d;
  logic [7:0]  rx_byte_q;
  logic        res_valid_q, res_valid_d;
  res_t        res_q;
  logic [15:0] poly_q;
  logic        step;
  res_beat_t   beat;

  assign step        = rx_valid_q && (!res_valid_q || res_o.ready);
  assign rx_i.ready  = !rx_valid_q || step;
  assign cfg_i.ready = 1'b1;

  cfd_frame_ctl u_frame_ctl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (rx_byte_q),
    .poly_i    (poly_q),
    .beat_o    (beat)
  );

  always_comb begin
    rx_valid_d = rx_valid_q;
    if (rx_i.valid && rx_i.ready) begin
      rx_valid_d = 1'b1;
    end else if (step) begin
      rx_valid_d = 1'b0;
    end

    res_valid_d = res_valid_q;
    if (step && beat.valid) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      poly_q      <= POLY_RESET;
    end else begin
      rx_valid_q  <= rx_valid_d;
      res_valid_q <= res_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        poly_q <= cfg_i.crc_poly;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      rx_byte_q <= rx_i.rx_byte;
    end
    if (step && beat.valid) begin
      res_q <= beat.res;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.kind        = res_q.kind;
  assign res_o.data        = res_q.data;
  assign res_o.vpid        = res_q.vpid;
  assign res_o.stream      = res_q.stream;
  assign res_o.payload_len = res_q.payload_len;
  assign res_o.last        = res_q.last;

  // A held byte is never overwritten before it has been processed.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_q && !step |-> !rx_i.ready)
    else $error("input register overrun");

  // A waiting result is not replaced while the receiver stalls.
  a_no_res_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.ready |=> res_valid_q && $stable(res_q))
    else $error("stalled result word was replaced");

  // A processed byte with a result always leaves it in the output register.
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && beat.valid |=> res_valid_q)
    else $error("result of a processed byte was lost");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Frame deframer testbench
// Feeds framed and noisy byte streams through the deframer under random
// source gaps and sink stalls, predicts every result word in step with the
// accepted bytes and checks the result words in order, across several CRC
// polynomial settings.
// ----------------------------------------------------------------------------
module tb_top;
  import cfd_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic clk_i;
  logic rst_ni;

  cfd_cfg_if cfg_if ();
  cfd_rx_if  rx_if ();
  cfd_res_if res_if ();

  crc_checked_frame_deframer_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // Bytes waiting to be sent and result words still due from the block.
  logic [7:0]  rx_bytes_q[$];
  res_t        results_due_q[$];
  int unsigned queued_bytes;

  int unsigned rx_idle_pct;
  int unsigned res_idle_pct;
  int unsigned rx_gap;
  int unsigned res_stall;
  int unsigned quiet_cycles;
  int unsigned mismatch_cnt;
  int unsigned results_seen;

  // Deframer state as predicted from the accepted bytes.
  phase_e      frm_phase;
  logic [2:0]  hdr_idx;
  logic [7:0]  hdr_chan;
  logic [7:0]  hdr_stream;
  logic [15:0] hdr_len;
  logic [15:0] hdr_crc;
  logic [7:0]  check_lo;
  logic [15:0] payload_left;
  logic [15:0] poly_now;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b,
                                             logic [15:0] poly);
    logic [15:0] r;
    r = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ poly) : (r << 1);
    end
    return r;
  endfunction

  function automatic res_t make_res(kind_e k, logic [7:0] d, logic [7:0] vp,
                                    logic [7:0] st, logic [15:0] len, logic lst);
    res_t r;
    r.kind        = k;
    r.data        = d;
    r.vpid        = vp;
    r.stream      = st;
    r.payload_len = len;
    r.last        = lst;
    return r;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic fin;
    case (frm_phase)
      PH_HUNT: begin
        if (b == START_BYTE) begin
          frm_phase = PH_HEADER;
          hdr_idx   = '0;
          hdr_crc   = CRC_INIT;
        end else begin
          results_due_q.push_back(make_res(KIND_DISCARD, b, '0, '0, '0, 1'b0));
        end
      end
      PH_HEADER: begin
        hdr_crc = crc16_step(hdr_crc, b, poly_now);
        case (hdr_idx[1:0])
          2'd0: hdr_chan = b;
          2'd1: hdr_stream = b;
          2'd2: hdr_len[7:0] = b;
          default: hdr_len[15:8] = b;
        endcase
        if (hdr_idx[1:0] == 2'd3) begin
          frm_phase = PH_CHECK;
          hdr_idx   = '0;
        end else begin
          hdr_idx = hdr_idx + 3'd1;
        end
      end
      PH_CHECK: begin
        if (hdr_idx == 3'd0) begin
          check_lo = b;
          hdr_idx  = 3'd1;
        end else begin
          hdr_idx = '0;
          if ({b, check_lo} == hdr_crc) begin
            results_due_q.push_back(make_res(KIND_HEADER, '0, hdr_chan, hdr_stream,
                                             hdr_len, hdr_len == 16'd0));
            payload_left = hdr_len;
            frm_phase    = (hdr_len == 16'd0) ? PH_HUNT : PH_PAYLOAD;
          end else begin
            results_due_q.push_back(make_res(KIND_CRC_ERR, '0, '0, '0, '0, 1'b0));
            frm_phase = PH_HUNT;
          end
        end
      end
      default: begin
        fin = (payload_left <= 16'd1);
        results_due_q.push_back(make_res(KIND_PAYLOAD, b, '0, '0, '0, fin));
        payload_left = fin ? 16'd0 : payload_left - 16'd1;
        if (fin) begin
          frm_phase = PH_HUNT;
        end
      end
    endcase
  endfunction

  function automatic int unsigned draw_wait(int unsigned pct);
    return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 19) : 0;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    rx_bytes_q.push_back(b);
    queued_bytes++;
  endfunction

  function automatic void add_frame(logic [7:0] ch, logic [7:0] st, logic [15:0] len,
                                    bit bad);
    logic [15:0] c;
    c = crc16_step(CRC_INIT, ch, poly_now);
    c = crc16_step(c, st, poly_now);
    c = crc16_step(c, len[7:0], poly_now);
    c = crc16_step(c, len[15:8], poly_now);
    if (bad) begin
      c = c ^ (16'h0001 << $urandom_range(0, 15));
    end
    push_byte(START_BYTE);
    push_byte(ch);
    push_byte(st);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    push_byte(c[7:0]);
    push_byte(c[15:8]);
    for (int i = 0; i < int'(len); i++) begin
      push_byte(($urandom_range(0, 9) == 0) ? START_BYTE : 8'($urandom_range(0, 255)));
    end
  endfunction

  // Mostly well-formed frames with random content, some with a corrupted
  // check, mixed with line noise and frames cut short after a few bytes.
  function automatic void random_traffic(int unsigned n);
    int unsigned stop;
    int unsigned sel;
    logic [15:0] len;
    stop = queued_bytes + n;
    while (queued_bytes < stop) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
          len = 16'd0;
        end else if (sel < 90) begin
          len = 16'($urandom_range(1, 12));
        end else begin
          len = 16'($urandom_range(13, 300));
        end
        add_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                  $urandom_range(0, 99) < 15);
      end else if (sel < 85) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(START_BYTE);
        repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic write_poly(logic [15:0] v);
    @(posedge clk_i);
    cfg_if.valid    <= 1'b1;
    cfg_if.crc_poly <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    poly_now = v;
  endtask

  // Waits until every byte is taken and every result word has come back, then
  // lets the last byte that causes no result work its way through.
  task automatic wait_drained();
    do @(negedge clk_i); while (rx_bytes_q.size() != 0 || results_due_q.size() != 0
                                || rx_if.valid);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic flag_error(string msg);
    if (mismatch_cnt < 10) begin
      $display("ERROR: %s", msg);
    end
    mismatch_cnt++;
  endtask

  // Byte driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
      rx_gap        <= 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.rx_byte);
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (rx_gap != 0) begin
          rx_gap      <= rx_gap - 1;
          rx_if.valid <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= rx_bytes_q.pop_front();
          rx_gap        <= draw_wait(rx_idle_pct);
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t        got;
    res_t        want;
    int unsigned stall_draw;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      res_stall    <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = make_res(kind_e'(res_if.kind), res_if.data, res_if.vpid, res_if.stream,
                       res_if.payload_len, res_if.last);
        if (results_due_q.size() == 0) begin
          flag_error($sformatf("result word %0d arrived with none due: kind %0d data %h",
                               results_seen, got.kind, got.data));
        end else begin
          want = results_due_q.pop_front();
          if (got !== want) begin
            flag_error($sformatf({"result word %0d: expected kind %0d data %h vpid %h ",
                                  "stream %h len %0d last %b, got kind %0d data %h ",
                                  "vpid %h stream %h len %0d last %b"},
                                 results_seen, want.kind, want.data, want.vpid,
                                 want.stream, want.payload_len, want.last, got.kind,
                                 got.data, got.vpid, got.stream, got.payload_len,
                                 got.last));
          end
        end
        results_seen <= results_seen + 1;
        stall_draw = draw_wait(res_idle_pct);
        res_stall    <= stall_draw;
        res_if.ready <= (stall_draw == 0);
      end else if (res_stall != 0) begin
        res_stall    <= res_stall - 1;
        res_if.ready <= (res_stall == 1);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // A run in which no word moves on any channel for too long has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)
          || (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d result words still due",
                 WATCHDOG_LIMIT, results_due_q.size());
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [15:0] split_crc;
    rst_ni          = 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.crc_poly <= '0;
    queued_bytes = 0;
    mismatch_cnt = 0;
    results_seen = 0;
    quiet_cycles = 0;
    rx_idle_pct  = 30;
    res_idle_pct = 30;
    frm_phase    = PH_HUNT;
    hdr_idx      = '0;
    hdr_chan     = '0;
    hdr_stream   = '0;
    hdr_len      = '0;
    hdr_crc      = CRC_INIT;
    check_lo     = '0;
    payload_left = '0;
    poly_now     = POLY_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the reset polynomial: extreme noise bytes, an empty
    // frame, a failed check with the start byte inside the header, and a
    // frame whose polynomial changes after its first two header bytes.
    @(negedge clk_i);
    push_byte(8'h00);
    push_byte(8'hFF);
    add_frame(8'hFF, 8'h00, 16'd0, 1'b0);
    add_frame(8'h5A, START_BYTE, 16'h0102, 1'b1);
    push_byte(START_BYTE);
    push_byte(8'h80);
    push_byte(8'h01);
    split_crc = crc16_step(crc16_step(CRC_INIT, 8'h80, poly_now), 8'h01, poly_now);
    wait_drained();
    write_poly(16'h8005);
    @(negedge clk_i);
    split_crc = crc16_step(crc16_step(split_crc, 8'h02, poly_now), 8'h00, poly_now);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(split_crc[7:0]);
    push_byte(split_crc[15:8]);
    push_byte(START_BYTE);
    push_byte(8'h00);
    random_traffic(90);
    wait_drained();

    write_poly(16'h0000);
    rx_idle_pct  = 70;
    res_idle_pct = 70;
    @(negedge clk_i);
    random_traffic(90);
    wait_drained();

    write_poly(16'hFFFF);
    rx_idle_pct  = 0;
    res_idle_pct = 0;
    @(negedge clk_i);
    random_traffic(90);
    wait_drained();

    write_poly(16'($urandom));
    rx_idle_pct  = 0;
    res_idle_pct = 80;
    @(negedge clk_i);
    random_traffic(90);
    wait_drained();

    write_poly(16'($urandom));
    rx_idle_pct  = 80;
    res_idle_pct = 0;
    @(negedge clk_i);
    random_traffic(90);
    wait_drained();

    // One more frame sent back to back, followed by a noise byte.
    rx_idle_pct  = 0;
    res_idle_pct = 0;
    add_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd40, 1'b0);
    push_byte(8'hFF);
    wait_drained();

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cfd_pkg.sv
rtl/cfd_if.sv
rtl/cfd_crc_fold.sv
rtl/cfd_frame_ctl.sv
rtl/crc_checked_frame_deframer_core.sv
tb/tb_top.sv
